>>> rtl/smtg_pkg.sv
// ----------------------------------------------------------------------------
// smtg_pkg
// Types and constants shared by the sphere-map texture coordinate generator.
// ----------------------------------------------------------------------------
package smtg_pkg;

    localparam int NORM_W  = 16;
    localparam int COEF_W  = 18;
    localparam int REG_W   = 3 * COEF_W;
    localparam int PROD_W  = NORM_W + COEF_W;
    localparam int ROT_W   = PROD_W + 2;
    localparam int MAG_W   = ROT_W - 2;
    localparam int SMAG_W  = 30;
    localparam int SQ_W    = 2 * SMAG_W;
    localparam int SSUM_W  = SQ_W + 2;
    localparam int RT_W    = SSUM_W + 1;
    localparam int LEN_W   = 31;
    localparam int ISQ_N   = 32;
    localparam int Q_W     = 16;
    localparam int NUM_W   = SMAG_W + Q_W;
    localparam int DIV_N   = Q_W + 1;
    localparam int TEX_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;
    localparam logic [TEX_W-1:0] HALF_Q16 = 16'h8000;

    typedef enum logic [1:0] {
        REG_COL_X = 2'd0,
        REG_COL_Y = 2'd1,
        REG_COL_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } in_word_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             degenerate;
    } out_word_t;

    typedef struct packed {
        logic              neg_u;
        logic              neg_v;
        logic              degen;
        logic [SMAG_W-1:0] mx;
        logic [SMAG_W-1:0] my;
    } side_t;

    typedef struct packed {
        logic [SSUM_W-1:0] sum_sq;
        side_t             side;
    } rot_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        side_t            side;
    } len_word_t;

    typedef struct packed {
        logic           neg_u;
        logic           neg_v;
        logic           degen;
        logic [Q_W-1:0] q_u;
        logic [Q_W-1:0] q_v;
    } quo_word_t;

endpackage

>>> rtl/smtg_rotate.sv
// ----------------------------------------------------------------------------
// smtg_rotate
// Matrix rotate, magnitude, range shift and sum of squares, six stages.
// ----------------------------------------------------------------------------
module smtg_rotate import smtg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  in_word_t         in_data,
    input  logic [REG_W-1:0] col_x,
    input  logic [REG_W-1:0] col_y,
    input  logic [REG_W-1:0] col_z,
    output logic             out_valid,
    output rot_word_t        out_data
);

    logic [5:0] v_reg;

    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [PROD_W-1:0] prod_reg  [9];
    logic signed [ROT_W-1:0]  rot_reg   [3];
    logic [MAG_W-1:0]         mag_reg   [3];
    logic                     nu_reg, nv_reg, dg_reg;
    logic [SMAG_W-1:0]        sm_reg    [3];
    logic                     nu2_reg, nv2_reg, dg2_reg;
    logic [SQ_W-1:0]          sq_reg    [3];
    side_t                    sd3_reg;
    logic [MAG_W-1:0]         mor;
    logic [MAG_W-1:0]         mag_next  [3];
    logic [SMAG_W-1:0]        sm_next   [3];
    logic signed [COEF_W-1:0] cf        [9];
    logic signed [NORM_W-1:0] nv        [3];

    always_comb begin
        nv[0] = in_data.normal_x;
        nv[1] = in_data.normal_y;
        nv[2] = in_data.normal_z;
        for (int i = 0; i < 3; i++) begin
            cf[i]     = col_x[COEF_W*i +: COEF_W];
            cf[3 + i] = col_y[COEF_W*i +: COEF_W];
            cf[6 + i] = col_z[COEF_W*i +: COEF_W];
        end
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                prod_next[3*j + i] = nv[i] * cf[3*j + i];
            end
        end
        for (int j = 0; j < 3; j++) begin
            mag_next[j] = rot_reg[j][ROT_W-1] ? MAG_W'(-rot_reg[j]) : MAG_W'(rot_reg[j]);
        end
        mor = mag_reg[0] | mag_reg[1] | mag_reg[2];
        for (int j = 0; j < 3; j++) begin
            if (mor[33]) begin
                sm_next[j] = SMAG_W'(mag_reg[j] >> 4);
            end else if (mor[32]) begin
                sm_next[j] = SMAG_W'(mag_reg[j] >> 3);
            end else if (mor[31]) begin
                sm_next[j] = SMAG_W'(mag_reg[j] >> 2);
            end else if (mor[30]) begin
                sm_next[j] = SMAG_W'(mag_reg[j] >> 1);
            end else begin
                sm_next[j] = SMAG_W'(mag_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= prod_next[k];
            end
            for (int j = 0; j < 3; j++) begin
                rot_reg[j] <= ROT_W'(prod_reg[3*j]) + ROT_W'(prod_reg[3*j + 1])
                              + ROT_W'(prod_reg[3*j + 2]);
                mag_reg[j] <= mag_next[j];
                sm_reg[j]  <= sm_next[j];
                sq_reg[j]  <= sm_reg[j] * sm_reg[j];
            end
            nu_reg  <= rot_reg[0][ROT_W-1];
            nv_reg  <= !rot_reg[1][ROT_W-1];
            dg_reg  <= (rot_reg[0] == '0) && (rot_reg[1] == '0) && (rot_reg[2] == '0);
            nu2_reg <= nu_reg;
            nv2_reg <= nv_reg;
            dg2_reg <= dg_reg;
            sd3_reg <= '{neg_u: nu2_reg, neg_v: nv2_reg, degen: dg2_reg,
                         mx: sm_reg[0], my: sm_reg[1]};
            out_data.sum_sq <= SSUM_W'(sq_reg[0]) + SSUM_W'(sq_reg[1]) + SSUM_W'(sq_reg[2]);
            out_data.side   <= sd3_reg;
        end
    end

    assign out_valid = v_reg[5];

endmodule

>>> rtl/smtg_isqrt.sv
// ----------------------------------------------------------------------------
// smtg_isqrt
// Floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module smtg_isqrt import smtg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  rot_word_t in_data,
    output logic      out_valid,
    output len_word_t out_data
);

    logic [RT_W-1:0] x_reg [ISQ_N];
    logic [RT_W-1:0] r_reg [ISQ_N];
    side_t           sd_reg [ISQ_N];
    logic [ISQ_N-1:0] v_reg;
    logic [RT_W-1:0] x_next [ISQ_N];
    logic [RT_W-1:0] r_next [ISQ_N];

    always_comb begin
        logic [RT_W-1:0] xi, ri, bk, t;
        for (int k = 0; k < ISQ_N; k++) begin
            xi = (k == 0) ? RT_W'(in_data.sum_sq) : x_reg[(k == 0) ? 0 : k - 1];
            ri = (k == 0) ? '0 : r_reg[(k == 0) ? 0 : k - 1];
            bk = RT_W'(1) << (RT_W - 1 - 2 * k);
            t  = ri + bk;
            if (xi >= t) begin
                x_next[k] = xi - t;
                r_next[k] = (ri >> 1) + bk;
            end else begin
                x_next[k] = xi;
                r_next[k] = ri >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ISQ_N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ISQ_N; k++) begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
                sd_reg[k] <= (k == 0) ? in_data.side : sd_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid     = v_reg[ISQ_N-1];
    assign out_data.len  = LEN_W'(r_reg[ISQ_N-1]);
    assign out_data.side = sd_reg[ISQ_N-1];

endmodule

>>> rtl/smtg_div.sv
// ----------------------------------------------------------------------------
// smtg_div
// Rounded ratio |c| * 2^15 / len for both lanes, restoring, bit per stage.
// ----------------------------------------------------------------------------
module smtg_div import smtg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  len_word_t in_data,
    output logic      out_valid,
    output quo_word_t out_data
);

    logic [NUM_W-1:0] ru_reg [DIV_N];
    logic [NUM_W-1:0] rv_reg [DIV_N];
    logic [Q_W-1:0]   qu_reg [DIV_N];
    logic [Q_W-1:0]   qv_reg [DIV_N];
    logic [LEN_W-1:0] d_reg  [DIV_N];
    logic [2:0]       f_reg  [DIV_N];
    logic [DIV_N-1:0] v_reg;
    logic [NUM_W-1:0] ru_next [DIV_N];
    logic [NUM_W-1:0] rv_next [DIV_N];
    logic [Q_W-1:0]   qu_next [DIV_N];
    logic [Q_W-1:0]   qv_next [DIV_N];

    always_comb begin
        logic [NUM_W-1:0] tr;
        logic [NUM_W-1:0] half;
        half = NUM_W'(in_data.len >> 1);
        ru_next[0] = (NUM_W'(in_data.side.mx) << (Q_W - 1)) + half;
        rv_next[0] = (NUM_W'(in_data.side.my) << (Q_W - 1)) + half;
        qu_next[0] = '0;
        qv_next[0] = '0;
        for (int k = 1; k < DIV_N; k++) begin
            tr = NUM_W'(d_reg[k-1]) << (DIV_N - 1 - k);
            ru_next[k] = ru_reg[k-1];
            rv_next[k] = rv_reg[k-1];
            qu_next[k] = qu_reg[k-1];
            qv_next[k] = qv_reg[k-1];
            if (ru_reg[k-1] >= tr) begin
                ru_next[k] = ru_reg[k-1] - tr;
                qu_next[k][DIV_N-1-k] = 1'b1;
            end
            if (rv_reg[k-1] >= tr) begin
                rv_next[k] = rv_reg[k-1] - tr;
                qv_next[k][DIV_N-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_N; k++) begin
                ru_reg[k] <= ru_next[k];
                rv_reg[k] <= rv_next[k];
                qu_reg[k] <= qu_next[k];
                qv_reg[k] <= qv_next[k];
                d_reg[k]  <= (k == 0) ? in_data.len : d_reg[(k == 0) ? 0 : k - 1];
                f_reg[k]  <= (k == 0) ?
                    {in_data.side.neg_u, in_data.side.neg_v, in_data.side.degen} :
                    f_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid      = v_reg[DIV_N-1];
    assign out_data.neg_u = f_reg[DIV_N-1][2];
    assign out_data.neg_v = f_reg[DIV_N-1][1];
    assign out_data.degen = f_reg[DIV_N-1][0];
    assign out_data.q_u   = qu_reg[DIV_N-1];
    assign out_data.q_v   = qv_reg[DIV_N-1];

endmodule

>>> rtl/sphere_map_texcoord_gen.sv
// ----------------------------------------------------------------------------
// sphere_map_texcoord_gen
// Rotates a vertex normal, normalizes it and emits sphere-map coordinates.
// ----------------------------------------------------------------------------
//  channel | ports                     | word
//  input   | s_valid s_ready s_data    | in_word_t (normal x, y, z)
//  result  | m_valid m_ready m_data    | out_word_t (u, v, degenerate)
//  config  | psel penable pwrite paddr | 54-bit matrix columns at 0, 8, 16
//
//  One word per cycle unless the output register stalls; each word passes the rotate,
//  bit-per-stage square root and bit-per-stage divider stages, then the output register.
//  Reset clears the valid bits and the matrix to zero.
//  A stalled output register freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module sphere_map_texcoord_gen import smtg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [REG_W-1:0] col_x_reg, col_y_reg, col_z_reg;
    logic             en;
    logic             rot_valid, len_valid, quo_valid;
    rot_word_t        rot_data;
    len_word_t        len_data;
    quo_word_t        quo_data;
    logic             m_valid_reg;
    out_word_t        m_data_reg;
    out_word_t        m_data_next;
    logic [TEX_W:0]   u_sum, v_sum;
    cfg_reg_t         idx;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign pready  = 1'b1;
    assign idx     = cfg_reg_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_x_reg <= '0;
            col_y_reg <= '0;
            col_z_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_COL_X: col_x_reg <= pwdata[REG_W-1:0];
                REG_COL_Y: col_y_reg <= pwdata[REG_W-1:0];
                REG_COL_Z: col_z_reg <= pwdata[REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_COL_X: prdata = DATA_W'(col_x_reg);
            REG_COL_Y: prdata = DATA_W'(col_y_reg);
            REG_COL_Z: prdata = DATA_W'(col_z_reg);
            default:   prdata = '0;
        endcase
    end

    smtg_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .col_x     (col_x_reg),
        .col_y     (col_y_reg),
        .col_z     (col_z_reg),
        .out_valid (rot_valid),
        .out_data  (rot_data)
    );

    smtg_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rot_valid),
        .in_data   (rot_data),
        .out_valid (len_valid),
        .out_data  (len_data)
    );

    smtg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (len_valid),
        .in_data   (len_data),
        .out_valid (quo_valid),
        .out_data  (quo_data)
    );

    always_comb begin
        u_sum = quo_data.neg_u ? (TEX_W+1)'(HALF_Q16) - (TEX_W+1)'(quo_data.q_u)
                               : (TEX_W+1)'(HALF_Q16) + (TEX_W+1)'(quo_data.q_u);
        v_sum = quo_data.neg_v ? (TEX_W+1)'(HALF_Q16) - (TEX_W+1)'(quo_data.q_v)
                               : (TEX_W+1)'(HALF_Q16) + (TEX_W+1)'(quo_data.q_v);
        m_data_next.tex_u = u_sum[TEX_W] ? '1 : u_sum[TEX_W-1:0];
        m_data_next.tex_v = v_sum[TEX_W] ? '1 : v_sum[TEX_W-1:0];
        m_data_next.degenerate = quo_data.degen;
        if (quo_data.degen) begin
            m_data_next.tex_u = HALF_Q16;
            m_data_next.tex_v = HALF_Q16;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= quo_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_degen_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.tex_u == HALF_Q16 && m_data.tex_v == HALF_Q16)
        else $error("degenerate word not centered");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_col_x_write: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && idx == REG_COL_X |=>
            col_x_reg == $past(pwdata[REG_W-1:0]))
        else $error("column x write lost");
`endif

endmodule

>>> verif/sphere_map_texcoord_gen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_map_texcoord_gen_tb
// Drives vertex normals through the texture coordinate generator under several
// normal matrices, predicts u, v and the zero-length flag in fixed point, and
// compares every result word in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sphere_map_texcoord_gen_tb;
    import smtg_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_word_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_word_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sphere_map_texcoord_gen dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [REG_W-1:0] matrix_cols [3];
    in_word_t         normal_queue [$];
    out_word_t        coord_queue [$];
    int               mismatches;
    bit               calm;
    bit               hold_sender;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [63:0] coef_of(logic [REG_W-1:0] col, int i);
        logic signed [COEF_W-1:0] c;
        c = col[COEF_W*i +: COEF_W];
        return 64'(c);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic out_word_t sphere_coords(in_word_t n);
        logic signed [63:0] r [3];
        logic [63:0]        mag [3];
        logic [63:0]        top;
        logic [63:0]        len;
        logic [63:0]        qx;
        logic [63:0]        qy;
        logic [63:0]        t;
        out_word_t          o;
        for (int k = 0; k < 3; k++) begin
            r[k] = 64'(n.normal_x) * coef_of(matrix_cols[k], 0)
                 + 64'(n.normal_y) * coef_of(matrix_cols[k], 1)
                 + 64'(n.normal_z) * coef_of(matrix_cols[k], 2);
            mag[k] = r[k] < 0 ? -r[k] : r[k];
        end
        if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
            o.tex_u = HALF_Q16;
            o.tex_v = HALF_Q16;
            o.degenerate = 1'b1;
            return o;
        end
        top = mag[0];
        if (mag[1] > top) top = mag[1];
        if (mag[2] > top) top = mag[2];
        while (top >= (64'd1 << 30)) begin
            top >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        qx = (mag[0] * 32768 + len / 2) / len;
        qy = (mag[1] * 32768 + len / 2) / len;
        t = r[0] < 0 ? 32768 - qx : 32768 + qx;
        o.tex_u = t > 65535 ? 16'hFFFF : t[15:0];
        t = r[1] >= 0 ? 32768 - qy : 32768 + qy;
        o.tex_v = t > 65535 ? 16'hFFFF : t[15:0];
        o.degenerate = 1'b0;
        return o;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'h08000;
            3: return 18'h38000;
            4: return 18'h0;
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_column();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic in_word_t rand_normal();
        in_word_t n;
        n.normal_x = 16'($urandom);
        n.normal_y = 16'($urandom);
        n.normal_z = 16'($urandom);
        if ($urandom_range(0, 9) == 0) n.normal_x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(0, 9) == 0) n.normal_y = 16'h0;
        return n;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (normal_queue.size() != 0 && !hold_sender
                    && (calm || $urandom_range(0, 99) >= 35)) begin
                s_valid <= 1'b1;
                s_data  <= normal_queue[0];
                coord_queue.push_back(sphere_coords(normal_queue[0]));
                normal_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (coord_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word u=%h v=%h d=%b",
                                 m_data.tex_u, m_data.tex_v, m_data.degenerate);
                end else begin
                    if (m_data !== coord_queue[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp u=%h v=%h d=%b got u=%h v=%h d=%b",
                                     coord_queue[0].tex_u, coord_queue[0].tex_v,
                                     coord_queue[0].degenerate, m_data.tex_u,
                                     m_data.tex_v, m_data.degenerate);
                    end
                    coord_queue.pop_front();
                end
            end
            m_ready <= calm || $urandom_range(0, 99) >= 35;
        end
    end

    task automatic write_column(cfg_reg_t idx, logic [REG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        matrix_cols[idx] = value;
    endtask

    task automatic load_matrix(logic [REG_W-1:0] cx, logic [REG_W-1:0] cy,
                               logic [REG_W-1:0] cz);
        write_column(REG_COL_X, cx);
        write_column(REG_COL_Y, cy);
        write_column(REG_COL_Z, cz);
    endtask

    task automatic drain();
        while (normal_queue.size() != 0 || coord_queue.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        in_word_t n;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        calm = 1'b0;
        hold_sender = 1'b0;
        for (int k = 0; k < 3; k++) matrix_cols[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // zero matrix after reset: everything is degenerate
        n = '0;
        normal_queue.push_back(n);
        normal_queue.push_back(rand_normal());
        drain();

        // identity, then directed extremes
        load_matrix({18'h0, 18'h0, 18'h08000}, {18'h0, 18'h08000, 18'h0},
                    {18'h08000, 18'h0, 18'h0});
        normal_queue.push_back('{16'h4000, 16'h0, 16'h0});
        normal_queue.push_back('{16'hC000, 16'h0, 16'h0});
        normal_queue.push_back('{16'h0, 16'h4000, 16'h0});
        normal_queue.push_back('{16'h0, 16'hC000, 16'h0});
        normal_queue.push_back('{16'h0, 16'h0, 16'h4000});
        normal_queue.push_back('{16'h0, 16'h0, 16'h0});
        normal_queue.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF});
        normal_queue.push_back('{16'h8000, 16'h8000, 16'h8000});
        normal_queue.push_back('{16'h0001, 16'h0, 16'h0});
        normal_queue.push_back('{16'hFFFF, 16'hFFFF, 16'h0});
        drain();

        // extreme coefficients
        load_matrix({3{18'h1FFFF}}, {3{18'h20000}}, {3{18'h3FFFF}});
        normal_queue.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF});
        normal_queue.push_back('{16'h8000, 16'h8000, 16'h8000});
        normal_queue.push_back('{16'h8000, 16'h7FFF, 16'h0});
        normal_queue.push_back('{16'h0001, 16'hFFFF, 16'h0});
        normal_queue.push_back('{16'h1234, 16'hEDCB, 16'h5A5A});
        drain();

        load_matrix({3{18'h20000}}, {3{18'h1FFFF}}, '0);
        normal_queue.push_back('{16'h8000, 16'h8000, 16'h8000});
        normal_queue.push_back('{16'h7FFF, 16'h0, 16'h0});
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            load_matrix(rand_column(), rand_column(), rand_column());
            calm = (phase == 3);
            for (int i = 0; i < 200; i++) normal_queue.push_back(rand_normal());
            if (phase == 5) begin
                while (normal_queue.size() > 100) @(posedge aclk);
                hold_sender = 1'b1;
                while (coord_queue.size() != 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0 && coord_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule

>>> files.f
rtl/smtg_pkg.sv
rtl/smtg_rotate.sv
rtl/smtg_isqrt.sv
rtl/smtg_div.sv
rtl/sphere_map_texcoord_gen.sv
verif/sphere_map_texcoord_gen_tb.sv
